FILE: hdl/lcpf_pkg.sv
package lcpf_pkg;

  // input operations
  localparam logic [2:0] OP_RX_BYTE   = 3'd0;
  localparam logic [2:0] OP_TICK      = 3'd1;
  localparam logic [2:0] OP_LINE_ERR  = 3'd2;
  localparam logic [2:0] OP_RELEASE   = 3'd3;
  localparam logic [2:0] OP_TX_BYTE   = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_RX_BYTE = 3'd1;
  localparam logic [2:0] KIND_ACCEPT  = 3'd2;
  localparam logic [2:0] KIND_REJECT  = 3'd3;
  localparam logic [2:0] KIND_TX_BYTE = 3'd4;

  localparam int unsigned BUFFER_BYTES     = 256;
  localparam logic [15:0] BUF_BYTES_16     = 16'(BUFFER_BYTES);
  localparam logic [7:0]  GAP_TICKS_RESET  = 8'd20;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // one run of results caused by one input word
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_val;
    logic [7:0]  index;
    logic [7:0]  frame_len;
    logic [15:0] tx_sum;
    logic        multi;     // two checksum bytes follow
  } run_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

FILE: hdl/lcpf_front.sv
module lcpf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              gap_ticks_we,
  input  logic [7:0]        gap_ticks,
  input  logic              accept,
  input  logic [2:0]        op,
  input  logic [7:0]        data,
  input  logic              last,
  output lcpf_pkg::run_t    run
);

  logic [7:0]  gap_ticks_reg;
  logic [15:0] rx_position, rx_position_next;
  logic        rx_discarding, rx_discarding_next;
  logic [15:0] expected_length, expected_length_next;
  logic [15:0] rx_sum, rx_sum_next;
  logic [7:0]  received_sum_high, received_sum_high_next;
  logic [7:0]  gap_timer, gap_timer_next;
  logic        packet_held, packet_held_next;
  logic [15:0] tx_sum, tx_sum_next;
  logic        tx_in_progress, tx_in_progress_next;

  logic        gap_expired;
  logic [15:0] pos_eff;
  logic        disc_eff;
  logic [15:0] len_new;
  logic [16:0] len_plus_one;
  logic [15:0] rx_sum_add;
  logic [15:0] got_sum;

  assign gap_expired  = (gap_timer == 8'd0);
  assign pos_eff      = gap_expired ? 16'd0 : rx_position;
  assign disc_eff     = gap_expired ? 1'b0 : rx_discarding;
  assign len_new      = {expected_length[15:8], data};
  assign len_plus_one = {1'b0, expected_length} + 17'd1;
  assign rx_sum_add   = rx_sum + {8'h00, data};
  assign got_sum      = {received_sum_high, data};

  always_comb begin
    rx_position_next       = rx_position;
    rx_discarding_next     = rx_discarding;
    expected_length_next   = expected_length;
    rx_sum_next            = rx_sum;
    received_sum_high_next = received_sum_high;
    gap_timer_next         = gap_timer;
    packet_held_next       = packet_held;
    tx_sum_next            = tx_sum;
    tx_in_progress_next    = tx_in_progress;
    run                    = '0;
    run.kind               = lcpf_pkg::KIND_NONE;

    case (op)
      lcpf_pkg::OP_RX_BYTE: begin
        if (!packet_held && !tx_in_progress) begin
          gap_timer_next = gap_ticks_reg;
          if (gap_expired) begin
            rx_position_next   = 16'd0;
            rx_discarding_next = 1'b0;
          end
          if (!disc_eff) begin
            if (pos_eff == 16'd0) begin
              expected_length_next = {data, 8'h00};
              rx_sum_next          = {8'h00, data};
              rx_position_next     = 16'd1;
              run.kind             = lcpf_pkg::KIND_RX_BYTE;
              run.byte_val         = data;
              run.index            = 8'd0;
            end else if (pos_eff == 16'd1) begin
              expected_length_next = len_new;
              rx_sum_next          = rx_sum_add;
              rx_position_next     = 16'd2;
              // reject lengths that cannot fit or cannot cover themselves
              if (len_new >= lcpf_pkg::BUF_BYTES_16 || len_new < 16'd2) begin
                rx_discarding_next = 1'b1;
              end
              run.kind     = lcpf_pkg::KIND_RX_BYTE;
              run.byte_val = data;
              run.index    = 8'd1;
            end else if (pos_eff < expected_length) begin
              rx_sum_next      = rx_sum_add;
              rx_position_next = pos_eff + 16'd1;
              run.kind         = lcpf_pkg::KIND_RX_BYTE;
              run.byte_val     = data;
              run.index        = pos_eff[7:0];
            end else if (pos_eff == expected_length) begin
              received_sum_high_next = data;
              rx_position_next       = pos_eff + 16'd1;
            end else if ({1'b0, pos_eff} == len_plus_one) begin
              rx_position_next = pos_eff + 16'd1;
              run.frame_len    = expected_length[7:0];
              if (got_sum == rx_sum) begin
                packet_held_next = 1'b1;
                run.kind         = lcpf_pkg::KIND_ACCEPT;
              end else begin
                run.kind = lcpf_pkg::KIND_REJECT;
              end
            end
          end
        end
      end
      lcpf_pkg::OP_TICK: begin
        if (!gap_expired) begin
          gap_timer_next = gap_timer - 8'd1;
        end
      end
      lcpf_pkg::OP_LINE_ERR: begin
        if (!packet_held && !tx_in_progress) begin
          rx_discarding_next = 1'b1;
        end
      end
      lcpf_pkg::OP_RELEASE: begin
        if (packet_held) begin
          packet_held_next   = 1'b0;
          rx_position_next   = 16'd0;
          rx_discarding_next = 1'b0;
        end
      end
      lcpf_pkg::OP_TX_BYTE: begin
        tx_sum_next         = tx_in_progress ? (tx_sum + {8'h00, data}) : {8'h00, data};
        tx_in_progress_next = 1'b1;
        run.kind            = lcpf_pkg::KIND_TX_BYTE;
        run.byte_val        = data;
        run.tx_sum          = tx_sum_next;
        if (last) begin
          run.multi           = 1'b1;
          tx_in_progress_next = 1'b0;
          packet_held_next    = 1'b0;
          rx_position_next    = 16'd0;
          rx_discarding_next  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks_reg     <= lcpf_pkg::GAP_TICKS_RESET;
      rx_position       <= '0;
      rx_discarding     <= 1'b0;
      expected_length   <= '0;
      rx_sum            <= '0;
      received_sum_high <= '0;
      gap_timer         <= '0;
      packet_held       <= 1'b0;
      tx_sum            <= '0;
      tx_in_progress    <= 1'b0;
    end else begin
      if (gap_ticks_we) begin
        gap_ticks_reg <= gap_ticks;
      end
      if (accept) begin
        rx_position       <= rx_position_next;
        rx_discarding     <= rx_discarding_next;
        expected_length   <= expected_length_next;
        rx_sum            <= rx_sum_next;
        received_sum_high <= received_sum_high_next;
        gap_timer         <= gap_timer_next;
        packet_held       <= packet_held_next;
        tx_sum            <= tx_sum_next;
        tx_in_progress    <= tx_in_progress_next;
      end
    end
  end

endmodule

FILE: hdl/lcpf_queue.sv
module lcpf_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  lcpf_pkg::run_t          push_data,
  input  logic                    pop,
  output lcpf_pkg::run_t          head,
  output lcpf_pkg::queue_status_t status
);

  lcpf_pkg::run_t                    entries [lcpf_pkg::QUEUE_DEPTH];
  logic [lcpf_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [lcpf_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [lcpf_pkg::QUEUE_CNT_W-1:0]  count;

  assign status.empty = (count == '0);
  assign status.full  = (count == lcpf_pkg::QUEUE_CNT_W'(lcpf_pkg::QUEUE_DEPTH));
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lcpf_pkg::QUEUE_PTR_W'(lcpf_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + lcpf_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lcpf_pkg::QUEUE_PTR_W'(lcpf_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + lcpf_pkg::QUEUE_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + lcpf_pkg::QUEUE_CNT_W'(1);
        2'b01:   count <= count - lcpf_pkg::QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= lcpf_pkg::QUEUE_CNT_W'(lcpf_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !status.full)
    else $error("push into full queue");

endmodule

FILE: hdl/lcpf_back.sv
module lcpf_back (
  input  logic                    clk,
  input  logic                    rst,
  input  lcpf_pkg::run_t          head,
  input  lcpf_pkg::queue_status_t status,
  output logic                    pop,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic [2:0]              kind,
  output logic [7:0]              byte_out,
  output logic [7:0]              index,
  output logic [7:0]              frame_len,
  output logic                    end_of_run
);

  typedef enum logic [2:0] {
    STEP_WORD   = 3'b001,
    STEP_SUM_HI = 3'b010,
    STEP_SUM_LO = 3'b100
  } step_t;

  step_t      step;
  logic       load;
  logic       run_end;

  // output register is free when empty or being taken this cycle
  assign load    = !status.empty && (!out_valid || !out_stall);
  assign run_end = (step == STEP_SUM_LO) || (step == STEP_WORD && !head.multi);
  assign pop     = load && run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= STEP_WORD;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= run_end ? STEP_WORD :
                     (step == STEP_WORD) ? STEP_SUM_HI : STEP_SUM_LO;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      end_of_run <= run_end;
      case (step)
        STEP_WORD: begin
          kind      <= head.kind;
          byte_out  <= head.byte_val;
          index     <= head.index;
          frame_len <= head.frame_len;
        end
        STEP_SUM_HI: begin
          kind      <= lcpf_pkg::KIND_TX_BYTE;
          byte_out  <= head.tx_sum[15:8];
          index     <= 8'd0;
          frame_len <= 8'd0;
        end
        default: begin
          kind      <= lcpf_pkg::KIND_TX_BYTE;
          byte_out  <= head.tx_sum[7:0];
          index     <= 8'd0;
          frame_len <= 8'd0;
        end
      endcase
    end
  end

  a_step_needs_multi: assert property (@(posedge clk) disable iff (rst)
    step != STEP_WORD |-> !status.empty && head.multi)
    else $error("checksum step without a pending last tx word");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    $onehot(step))
    else $error("step register not one-hot");

  a_multi_advances: assert property (@(posedge clk) disable iff (rst)
    load && step == STEP_SUM_HI |=> step == STEP_SUM_LO && out_valid)
    else $error("checksum high byte not followed by low byte");

endmodule

FILE: hdl/length_checksum_packet_framer.sv
// Length-prefixed packet framer/deframer with a 16-bit additive checksum.
//
// Input channel (in_valid / in_stall): one word of op, data, last. A word is
// taken when in_valid is high and in_stall is low. The front end updates all
// framing state in the cycle the word is taken and queues its results.
// Output channel (out_valid / out_stall): one to three results per word
// taken, with end_of_run marking the last result caused by one input word.
// Path: results of a taken word pass through the run queue and then the
// output register. Throughput: one input word per cycle while in_stall is
// low; a transmit word marked last yields three results, which the
// four-entry run queue absorbs.
// Receiver stall: the output register holds its result; the queue keeps
// filling and in_stall rises only when all four entries are taken.
// Only write gap_ticks (gap_ticks_we) while the block is idle; not enforced.
// Reset (rst, synchronous): clears all framing state and the queue, sets
// gap_ticks to 20; the block takes words on the next cycle.
module length_checksum_packet_framer (
  input  logic       clk,
  input  logic       rst,
  input  logic       gap_ticks_we,
  input  logic [7:0] gap_ticks,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] op,
  input  logic [7:0] data,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic [7:0] byte_out,
  output logic [7:0] index,
  output logic [7:0] frame_len,
  output logic       end_of_run
);

  lcpf_pkg::run_t          run;
  lcpf_pkg::run_t          head;
  lcpf_pkg::queue_status_t status;
  logic                    accept;
  logic                    pop;

  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  lcpf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .gap_ticks_we (gap_ticks_we),
    .gap_ticks    (gap_ticks),
    .accept       (accept),
    .op           (op),
    .data         (data),
    .last         (last),
    .run          (run)
  );

  lcpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (run),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  lcpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .status     (status),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .kind       (kind),
    .byte_out   (byte_out),
    .index      (index),
    .frame_len  (frame_len),
    .end_of_run (end_of_run)
  );

endmodule

FILE: sim/tb_length_checksum_packet_framer.sv
module tb_length_checksum_packet_framer;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_val;
    logic [7:0] index;
    logic [7:0] frame_len;
    logic       end_of_run;
  } framer_result_t;

  // Tracks the framing state word by word and queues the results due.
  class framing_tracker;
    bit [7:0]  gap_cfg;
    bit [15:0] rx_pos;
    bit        rx_drop;
    bit [15:0] length_field;
    bit [15:0] rx_sum;
    bit [7:0]  sum_high;
    bit [7:0]  gap_left;
    bit        held;
    bit [15:0] tx_sum;
    bit        tx_busy;
    framer_result_t due_results[$];
    int errors;

    function new();
      gap_cfg = lcpf_pkg::GAP_TICKS_RESET;
      rx_pos = '0;
      rx_drop = 1'b0;
      length_field = '0;
      rx_sum = '0;
      sum_high = '0;
      gap_left = '0;
      held = 1'b0;
      tx_sum = '0;
      tx_busy = 1'b0;
      errors = 0;
    endfunction

    function void add(logic [2:0] k, logic [7:0] b, logic [7:0] idx, logic [7:0] flen);
      framer_result_t r;
      r.kind = k;
      r.byte_val = b;
      r.index = idx;
      r.frame_len = flen;
      r.end_of_run = 1'b0;
      due_results.push_back(r);
    endfunction

    function void restart_rx();
      rx_pos = '0;
      rx_drop = 1'b0;
    endfunction

    function void take_rx(bit [7:0] d);
      bit [15:0] pos;
      if (held || tx_busy) return;
      if (gap_left == 0) restart_rx();
      gap_left = gap_cfg;
      if (rx_drop) return;
      pos = rx_pos;
      if (pos == 0) begin
        length_field = {d, 8'h00};
        rx_sum = {8'h00, d};
        rx_pos = 16'd1;
        add(lcpf_pkg::KIND_RX_BYTE, d, 8'd0, 8'd0);
      end else if (pos == 1) begin
        length_field[7:0] = d;
        rx_sum = rx_sum + 16'(d);
        rx_pos = 16'd2;
        if (length_field >= lcpf_pkg::BUF_BYTES_16 || length_field < 16'd2) rx_drop = 1'b1;
        add(lcpf_pkg::KIND_RX_BYTE, d, 8'd1, 8'd0);
      end else if (pos < length_field) begin
        rx_sum = rx_sum + 16'(d);
        rx_pos = pos + 16'd1;
        add(lcpf_pkg::KIND_RX_BYTE, d, pos[7:0], 8'd0);
      end else if (pos == length_field) begin
        sum_high = d;
        rx_pos = pos + 16'd1;
      end else if (pos == length_field + 16'd1) begin
        rx_pos = pos + 16'd1;
        if ({sum_high, d} == rx_sum) begin
          held = 1'b1;
          add(lcpf_pkg::KIND_ACCEPT, 8'd0, 8'd0, length_field[7:0]);
        end else begin
          add(lcpf_pkg::KIND_REJECT, 8'd0, 8'd0, length_field[7:0]);
        end
      end
    endfunction

    function void note_word(bit [2:0] w_op, bit [7:0] d, bit lst);
      int first;
      framer_result_t r;
      first = due_results.size();
      case (w_op)
        lcpf_pkg::OP_RX_BYTE: take_rx(d);
        lcpf_pkg::OP_TICK: if (gap_left != 0) gap_left = gap_left - 8'd1;
        lcpf_pkg::OP_LINE_ERR: if (!held && !tx_busy) rx_drop = 1'b1;
        lcpf_pkg::OP_RELEASE: begin
          if (held) begin
            held = 1'b0;
            restart_rx();
          end
        end
        lcpf_pkg::OP_TX_BYTE: begin
          tx_sum = tx_busy ? tx_sum + 16'(d) : {8'h00, d};
          tx_busy = 1'b1;
          add(lcpf_pkg::KIND_TX_BYTE, d, 8'd0, 8'd0);
          if (lst) begin
            add(lcpf_pkg::KIND_TX_BYTE, tx_sum[15:8], 8'd0, 8'd0);
            add(lcpf_pkg::KIND_TX_BYTE, tx_sum[7:0], 8'd0, 8'd0);
            tx_busy = 1'b0;
            held = 1'b0;
            restart_rx();
          end
        end
        default: ;
      endcase
      if (due_results.size() == first) add(lcpf_pkg::KIND_NONE, 8'd0, 8'd0, 8'd0);
      r = due_results.pop_back();
      r.end_of_run = 1'b1;
      due_results.push_back(r);
    endfunction

    function void check_result(framer_result_t got);
      framer_result_t exp;
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing due: kind %0d byte %h", $time, got.kind,
                 got.byte_val);
        errors++;
        return;
      end
      exp = due_results.pop_front();
      if (got.kind !== exp.kind) begin
        $display("%0t: kind expected %0d got %0d", $time, exp.kind, got.kind);
        errors++;
      end
      if (got.byte_val !== exp.byte_val) begin
        $display("%0t: byte_out expected %h got %h", $time, exp.byte_val, got.byte_val);
        errors++;
      end
      if (got.index !== exp.index) begin
        $display("%0t: index expected %0d got %0d", $time, exp.index, got.index);
        errors++;
      end
      if (got.frame_len !== exp.frame_len) begin
        $display("%0t: frame_len expected %0d got %0d", $time, exp.frame_len, got.frame_len);
        errors++;
      end
      if (got.end_of_run !== exp.end_of_run) begin
        $display("%0t: end_of_run expected %0d got %0d", $time, exp.end_of_run,
                 got.end_of_run);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       gap_ticks_we = 1'b0;
  logic [7:0] gap_ticks = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] op = 3'd0;
  logic [7:0] data = 8'd0;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] kind;
  logic [7:0] byte_out;
  logic [7:0] index;
  logic [7:0] frame_len;
  logic       end_of_run;

  framing_tracker tracker;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int cycle_count = 0;
  bit hold_start = 1'b0;
  int hold_left = 0;

  length_checksum_packet_framer i_dut (
    .clk(clk),
    .rst(rst),
    .gap_ticks_we(gap_ticks_we),
    .gap_ticks(gap_ticks),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .data(data),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .byte_out(byte_out),
    .index(index),
    .frame_len(frame_len),
    .end_of_run(end_of_run)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("length_checksum_packet_framer regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : watch_results
    framer_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.kind = kind;
      got.byte_val = byte_out;
      got.index = index;
      got.frame_len = frame_len;
      got.end_of_run = end_of_run;
      tracker.check_result(got);
    end
  end

  task automatic send_word(input logic [2:0] w_op, input logic [7:0] w_data,
                           input logic w_last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= w_op;
    data <= w_data;
    last <= w_last;
    // hold the word until it is taken
    do @(posedge clk); while (in_stall);
    tracker.note_word(w_op, w_data, w_last);
    words_sent++;
  endtask

  task automatic write_gap(input logic [7:0] value);
    @(negedge clk);
    gap_ticks_we <= 1'b1;
    gap_ticks <= value;
    @(posedge clk);
    tracker.gap_cfg = value;
    @(negedge clk);
    gap_ticks_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_tx_frame(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      // receive side is locked while a frame goes out
      if ($urandom_range(0, 5) == 0)
        send_word($urandom_range(0, 1) ? lcpf_pkg::OP_RX_BYTE : lcpf_pkg::OP_LINE_ERR,
                  8'($urandom), 1'b0);
      send_word(lcpf_pkg::OP_TX_BYTE, 8'($urandom), i == n - 1);
    end
  endtask

  task automatic send_packet(input bit [15:0] len, input bit sum_ok);
    bit [15:0] sum;
    bit [7:0] b;
    int i;
    int extra;
    sum = 16'(len[15:8]) + 16'(len[7:0]);
    send_word(lcpf_pkg::OP_RX_BYTE, len[15:8], 1'($urandom_range(0, 1)));
    send_word(lcpf_pkg::OP_RX_BYTE, len[7:0], 1'($urandom_range(0, 1)));
    if (len < 16'd2 || len >= lcpf_pkg::BUF_BYTES_16) begin
      extra = $urandom_range(0, 4);
      for (i = 0; i < extra; i++) send_word(lcpf_pkg::OP_RX_BYTE, 8'($urandom), 1'b0);
      return;
    end
    for (i = 2; i < len; i++) begin
      case ($urandom_range(0, 59))
        0, 1: send_word(lcpf_pkg::OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
        2: send_word(lcpf_pkg::OP_LINE_ERR, 8'($urandom), 1'($urandom_range(0, 1)));
        default: ;
      endcase
      b = 8'($urandom);
      sum = sum + 16'(b);
      send_word(lcpf_pkg::OP_RX_BYTE, b, 1'($urandom_range(0, 1)));
    end
    if (!sum_ok) sum = sum ^ 16'($urandom_range(1, 65535));
    send_word(lcpf_pkg::OP_RX_BYTE, sum[15:8], 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, sum[7:0], 1'b0);
    if ($urandom_range(0, 7) == 0) send_word(lcpf_pkg::OP_RX_BYTE, 8'($urandom), 1'b0);
  endtask

  // bring the receive side back to the start of a packet
  task automatic open_rx();
    if (tracker.tx_busy) send_word(lcpf_pkg::OP_TX_BYTE, 8'($urandom), 1'b1);
    if (tracker.held) begin
      if ($urandom_range(0, 1))
        send_word(lcpf_pkg::OP_RELEASE, 8'($urandom), 1'($urandom_range(0, 1)));
      else send_tx_frame($urandom_range(1, 3));
    end else if (tracker.rx_pos != 0 || tracker.rx_drop) begin
      if (tracker.gap_left <= 8'd6) begin
        while (tracker.gap_left != 0) send_word(lcpf_pkg::OP_TICK, 8'($urandom), 1'b0);
      end else begin
        send_tx_frame($urandom_range(1, 3));
      end
    end
  endtask

  task automatic random_phase(input int n);
    int stop;
    int pick;
    int shape;
    bit [15:0] len;
    stop = words_sent + n;
    while (words_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        open_rx();
        shape = $urandom_range(0, 15);
        if (shape == 0) len = 16'($urandom_range(0, 1));
        else if (shape == 1) len = 16'($urandom_range(256, 65535));
        else len = 16'($urandom_range(2, 12));
        send_packet(len, $urandom_range(0, 4) != 0);
      end else if (pick < 70) begin
        send_tx_frame($urandom_range(1, 6));
      end else begin
        send_word(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send_idle_pct = 26;
    stall_pct = 75;
    write_gap(8'd1);
    // good packet, then held
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h00, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h04, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'hAA, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h55, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h01, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h03, 1'b0);
    // locked while held, release, release with nothing held
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h12, 1'b0);
    send_word(lcpf_pkg::OP_LINE_ERR, 8'h00, 1'b0);
    send_word(lcpf_pkg::OP_RELEASE, 8'h00, 1'b0);
    send_word(lcpf_pkg::OP_RELEASE, 8'hFF, 1'b1);
    // oversized length
    send_word(lcpf_pkg::OP_TICK, 8'h00, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'hFF, 1'b1);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'hFF, 1'b1);
    // length too short to hold itself
    send_word(lcpf_pkg::OP_TICK, 8'h00, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h00, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h01, 1'b0);
    // bad checksum, then a byte past the checksum
    send_word(lcpf_pkg::OP_TICK, 8'h00, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h00, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h02, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h00, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h03, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h99, 1'b0);
    // line error drops the rest of the packet
    send_word(lcpf_pkg::OP_TICK, 8'h00, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h00, 1'b0);
    send_word(lcpf_pkg::OP_LINE_ERR, 8'h00, 1'b0);
    send_word(lcpf_pkg::OP_RX_BYTE, 8'h05, 1'b0);
    // transmit frame with checksum, unused ops
    send_word(lcpf_pkg::OP_TX_BYTE, 8'h80, 1'b0);
    send_word(lcpf_pkg::OP_TX_BYTE, 8'hFF, 1'b1);
    send_word(OP_UNUSED_LO, 8'h5A, 1'b1);
    send_word(OP_UNUSED_HI, 8'hA5, 1'b0);
    drain();

    write_gap(8'd255);
    random_phase(60);
    drain();

    send_idle_pct = 75;
    stall_pct = 26;
    write_gap(8'd0);
    random_phase(25);
    drain();

    write_gap(8'd3);
    random_phase(50);
    drain();

    send_idle_pct = 0;
    stall_pct = 0;
    write_gap(lcpf_pkg::GAP_TICKS_RESET);
    hold_start = 1'b1;
    send_packet(16'd16, 1'b1);
    random_phase(55);
    drain();
    repeat (8) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("length_checksum_packet_framer regression: pass");
    end else begin
      $display("length_checksum_packet_framer regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lcpf_pkg.sv
hdl/lcpf_front.sv
hdl/lcpf_queue.sv
hdl/lcpf_back.sv
hdl/length_checksum_packet_framer.sv
sim/tb_length_checksum_packet_framer.sv
